/* hw/rtl/indexed_insert_remove_list_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the indexed insert/remove list
// Short forms for the concurrent checks used in the list's RTL.
// ---------------------------------------------------------------------------
`ifndef INDEXED_INSERT_REMOVE_LIST_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIRL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IIRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/iirl_pkg.sv */
// ---------------------------------------------------------------------------
// Indexed insert/remove list package
// Operation and status codes, cell command and response word types.
// ---------------------------------------------------------------------------
package iirl_pkg;

   // Width of a list position inside the cell row; covers counts up to 2047.
   localparam int CELL_POS_W = 11;

   // Fixed widths of the response fields.
   localparam int RSP_VALUE_W = 32;
   localparam int RSP_COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_APPEND = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD = 2'd0,
      SHIFT_UP   = 2'd1,
      SHIFT_DOWN = 2'd2
   } shift_type;

   typedef enum logic [1:0] {
      CTRL_IDLE   = 2'd0,
      CTRL_GATHER = 2'd1,
      CTRL_MERGE  = 2'd2
   } ctrl_state_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      shift_type              shift;
      logic [CELL_POS_W-1:0]  pos;
   } cell_cmd_type;

   // One response word as it waits in the output queue.
   typedef struct packed {
      status_type              status;
      logic [RSP_VALUE_W-1:0]  read_value;
      logic [RSP_COUNT_W-1:0]  element_count;
      logic                    is_empty;
   } rsp_word_type;

endpackage

/* hw/rtl/indexed_insert_remove_list.sv */
// ---------------------------------------------------------------------------
// Indexed insert/remove list
// Ordered list with insert, append, remove and read at a position.
// ---------------------------------------------------------------------------
// The list is a row of CAPACITY cells, one entry each; cells at and above the
// addressed position shift together in the same cycle. Insert, append, remove
// and every request that fails its range or full check leave the controller
// idle, so the next word is accepted unless the output queue is full. A
// successful read stalls requests through the gather and merge states: the
// addressed cell is merged through a registered 32-way OR level, then a second
// OR level into the two-word output queue, which lets the block take a request
// while an earlier response stalls. Elements have no reset; the count is cleared.
// ---------------------------------------------------------------------------
`include "indexed_insert_remove_list_macros.svh"

module indexed_insert_remove_list #(
   parameter int CAPACITY      = 64,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_operation,
   input  logic [6:0]   req_position,
   input  logic [31:0]  req_element_value,

   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_read_value,
   output logic [6:0]   rsp_element_count,
   output logic         rsp_is_empty
);
   import iirl_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

   ctrl_state_type            state_ff;
   ctrl_state_type            state_in;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic [CELL_POS_W-1:0]     pos_ff;
   logic [CELL_POS_W-1:0]     pos_in;

   logic [1:0]                q_ff;
   logic [1:0]                q_in;
   rsp_word_type              slot0_ff;
   rsp_word_type              slot0_in;
   rsp_word_type              slot1_ff;
   rsp_word_type              slot1_in;

   logic                      req_accept;
   logic                      pop;
   logic                      push;
   rsp_word_type              push_word;
   logic                      remove_ok;
   cell_cmd_type              cmd;
   logic [ELEMENT_WIDTH-1:0]  insert_value;
   logic [ELEMENT_WIDTH-1:0]  tree_value;
   logic [ELEMENT_WIDTH-1:0]  cell_value [CAPACITY];
   logic [ELEMENT_WIDTH-1:0]  cell_read  [CAPACITY];

   // Handshakes.
   assign req_stall  = (state_ff != CTRL_IDLE) || (q_ff == 2'd2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (q_ff != 2'd0);
   assign pop        = rsp_valid && !rsp_stall;

   assign insert_value = ELEMENT_WIDTH'(req_element_value);

   // Request decode, cell command and sequencing of reads.
   always_comb begin
      op_type                 op;
      logic [CELL_POS_W-1:0]  pos_req;
      logic [CELL_POS_W-1:0]  cnt_ext;
      logic [CELL_POS_W-1:0]  ins_pos;

      op        = op_type'(req_operation);
      pos_req   = CELL_POS_W'(req_position);
      cnt_ext   = CELL_POS_W'(count_ff);
      ins_pos   = (op == OP_APPEND) ? cnt_ext : pos_req;
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      push      = 1'b0;
      remove_ok = 1'b0;
      cmd.shift = SHIFT_HOLD;
      cmd.pos   = pos_ff;
      push_word = '0;
      push_word.status = ST_OK;

      unique case (state_ff)
         CTRL_IDLE: begin
            cmd.pos = pos_req;
            if (req_accept) begin
               unique case (op)
                  OP_INSERT, OP_APPEND: begin
                     push = 1'b1;
                     if (ins_pos > cnt_ext) begin
                        push_word.status = ST_RANGE;
                     end else if (count_ff == FULL_COUNT) begin
                        push_word.status = ST_FULL;
                     end else begin
                        cmd.shift = SHIFT_UP;
                        cmd.pos   = ins_pos;
                        count_in  = count_ff + COUNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     push = 1'b1;
                     if (pos_req >= cnt_ext) begin
                        push_word.status = ST_RANGE;
                     end else begin
                        cmd.shift = SHIFT_DOWN;
                        remove_ok = 1'b1;
                        count_in  = count_ff - COUNT_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (pos_req >= cnt_ext) begin
                        push = 1'b1;
                        push_word.status = ST_RANGE;
                     end else begin
                        pos_in   = pos_req;
                        state_in = CTRL_GATHER;
                     end
                  end
                  default: push = 1'b0;
               endcase
            end
         end
         CTRL_GATHER: begin
            state_in = CTRL_MERGE;
         end
         CTRL_MERGE: begin
            push = 1'b1;
            push_word.read_value = RSP_VALUE_W'(tree_value);
            state_in = CTRL_IDLE;
         end
         default: state_in = CTRL_IDLE;
      endcase

      push_word.element_count = RSP_COUNT_W'(count_in);
      push_word.is_empty      = (count_in == '0);
   end

   // Output queue of two words; the head drives the response ports.
   always_comb begin
      q_in     = q_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      priority if (push && pop) begin
         if (q_ff == 2'd2) begin
            slot0_in = slot1_ff;
            slot1_in = push_word;
         end else begin
            slot0_in = push_word;
         end
      end else if (push) begin
         if (q_ff == 2'd0) begin
            slot0_in = push_word;
         end else begin
            slot1_in = push_word;
         end
         q_in = q_ff + 2'd1;
      end else if (pop) begin
         slot0_in = slot1_ff;
         q_in     = q_ff - 2'd1;
      end else begin
         q_in = q_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
         count_ff <= '0;
         q_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         q_ff     <= q_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_status        = slot0_ff.status;
   assign rsp_read_value    = slot0_ff.read_value;
   assign rsp_element_count = slot0_ff.element_count;
   assign rsp_is_empty      = slot0_ff.is_empty;

   // Row of cells; each end cell takes a fixed neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEMENT_WIDTH-1:0] left_value;
      logic [ELEMENT_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[i - 1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner_right
         assign right_value = cell_value[i + 1];
      end

      iirl_cell #(
         .INDEX         (i),
         .ELEMENT_WIDTH (ELEMENT_WIDTH)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .insert_value (insert_value),
         .left_value   (left_value),
         .right_value  (right_value),
         .value        (cell_value[i]),
         .read_word    (cell_read[i])
      );
   end

   // Read path over the whole row.
   iirl_read_tree #(
      .CAPACITY      (CAPACITY),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_read_tree (
      .clock      (clock),
      .words      (cell_read),
      .read_value (tree_value)
   );

   // The count never passes the capacity.
   `IIRL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT,
                    "count above capacity")

   // The output queue holds at most two words.
   `IIRL_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, q_ff != 2'd3,
                    "output queue overflow")

   // A read goes from gather straight to merge.
   `IIRL_ASSERT_NEXT(a_read_seq, clock, reset, state_ff == CTRL_GATHER,
                     state_ff == CTRL_MERGE, "read sequence broken")

   // A successful remove lowers the count by one.
   `IIRL_ASSERT_NEXT(a_remove_count, clock, reset, remove_ok,
                     count_ff == $past(count_ff) - COUNT_W'(1), "remove count wrong")

endmodule

/* hw/rtl/iirl_cell.sv */
// ---------------------------------------------------------------------------
// List cell
// Holds one list entry and shifts it toward either neighbor on command.
// ---------------------------------------------------------------------------
module iirl_cell #(
   parameter int INDEX         = 0,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                      clock,
   input  iirl_pkg::cell_cmd_type    cmd,
   input  logic [ELEMENT_WIDTH-1:0]  insert_value,
   input  logic [ELEMENT_WIDTH-1:0]  left_value,
   input  logic [ELEMENT_WIDTH-1:0]  right_value,
   output logic [ELEMENT_WIDTH-1:0]  value,
   output logic [ELEMENT_WIDTH-1:0]  read_word
);
   import iirl_pkg::*;

   localparam logic [CELL_POS_W-1:0] MY_INDEX = CELL_POS_W'(INDEX);

   logic                      at_pos;
   logic                      above_pos;
   logic [ELEMENT_WIDTH-1:0]  data_ff;
   logic [ELEMENT_WIDTH-1:0]  data_in;

   // Where this cell sits relative to the addressed position.
   assign at_pos    = (cmd.pos == MY_INDEX);
   assign above_pos = (cmd.pos < MY_INDEX);

   // Next entry: on insert take the left neighbor above the position and the new value at it; on remove the right one.
   always_comb begin
      data_in = data_ff;
      unique case (cmd.shift)
         SHIFT_HOLD: data_in = data_ff;
         SHIFT_UP: begin
            if (above_pos) begin
               data_in = left_value;
            end else if (at_pos) begin
               data_in = insert_value;
            end
         end
         SHIFT_DOWN: begin
            if (at_pos || above_pos) begin
               data_in = right_value;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign value     = data_ff;
   assign read_word = at_pos ? data_ff : '0;

endmodule

/* hw/rtl/iirl_read_tree.sv */
// ---------------------------------------------------------------------------
// Read merge tree
// Combines the gated cell words in groups of 32 with one register stage.
// ---------------------------------------------------------------------------
module iirl_read_tree #(
   parameter int CAPACITY      = 64,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic [ELEMENT_WIDTH-1:0]  words [CAPACITY],
   output logic [ELEMENT_WIDTH-1:0]  read_value
);
   import iirl_pkg::*;

   localparam int GROUP_SIZE = 32;
   localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [ELEMENT_WIDTH-1:0] group_in [GROUPS];
   logic [ELEMENT_WIDTH-1:0] group_ff [GROUPS];

   // First level: OR of each group of cells; only the addressed cell is nonzero.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               group_in[g] = group_in[g] | words[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   // Second level: OR of the registered group results.
   always_comb begin
      read_value = '0;
      for (int g = 0; g < GROUPS; g++) begin
         read_value = read_value | group_ff[g];
      end
   end

endmodule
